### src/agb_pkg.sv
// shared types and constants for the argb gaussian blur block
// no dependencies; imported by argb_gaussian_blur_top
package agb_pkg;

   // store geometry and window limit
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 3;

   // field widths fixed by the item format
   localparam int COORD_W  = 8;
   localparam int PIXEL_W  = 32;
   localparam int SIZE_W   = 9;
   localparam int RADIUS_W = 2;
   localparam int WEIGHT_W = 16;

   // q1.15 weight of one, largest legal weight
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

   // accumulator widths: one tap weight, weight sum and channel sums
   localparam int TAPS   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int WT_W   = 2 * WEIGHT_W - 1;
   localparam int TAP_W  = $clog2(TAPS + 1);
   localparam int WSUM_W = WT_W + TAP_W;
   localparam int SUM_W  = WSUM_W + 8;
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_BLUR_RADIUS  = 3'd2,
      REG_WEIGHT_ZERO  = 3'd3,
      REG_WEIGHT_ONE   = 3'd4,
      REG_WEIGHT_TWO   = 3'd5,
      REG_WEIGHT_THREE = 3'd6
   } reg_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_BLUR = 1'b1
   } command_type;

   typedef struct packed {
      logic                 command;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [PIXEL_W-1:0]   pixel_in;
   } req_item_type;

   typedef struct packed {
      logic                 in_range;
      logic [PIXEL_W-1:0]   pixel_out;
   } rsp_item_type;

endpackage

### src/argb_gaussian_blur_top.sv
// argb gaussian blur: pixel store, window walk with one shared multiplier,
// bit-serial division per channel; depends on agb_pkg
//
// Usage:
//   req channel (req_valid/req_ready, req_payload) takes load and blur items.
//   A load item writes pixel_in at (col,row) into the 64K-word store and
//   gives no result. A blur item gives one rsp item: in_range and
//   the blurred pixel, or in_range=0 and zero outside the configured image.
//   The csr port is APB-style, pready always high; registers at 4*index.
// Operation:
//   The block takes one item at a time and req_ready is low while it works.
//   An out-of-range blur item goes from setup straight to delivery. An
//   in-range blur item walks the (2r+1)^2 window: each tap is one store
//   read plus a weight product and four channel products on the shared
//   multiplier, then four 8-step restoring divisions.
// Reset and stall:
//   Synchronous reset restores the configuration defaults and empties the
//   result register; the store is not cleared and must be loaded first.
//   A finished result waits in the rsp register; new items are accepted
//   meanwhile, and the next blur result holds until the register is free.
module argb_gaussian_blur_top
   import agb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_item_type            req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_item_type            rsp_payload,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_TAP,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DELIVER
   } state_type;

   // configuration registers
   logic [SIZE_W-1:0]     width_ff, height_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic [WEIGHT_W-1:0]   weight_ff [4];

   // sequencer state
   state_type             state_ff;
   logic [COORD_W-1:0]    col_ff, row_ff;
   logic [SIZE_W-1:0]     w_eff_ff, h_eff_ff;
   logic                  in_range_ff;
   logic signed [3:0]     dx_ff, dy_ff;
   logic [2:0]            step_ff;
   logic [1:0]            ch_ff;
   logic [2:0]            bit_ff;
   logic [7:0]            quot_ff;
   logic [WT_W-1:0]       wt_ff;
   logic [WT_W+WEIGHT_W-1:0] mul_ff;
   logic [WSUM_W-1:0]     wsum_ff;
   logic [SUM_W-1:0]      sum_ff [4];
   logic [SUM_W-1:0]      rem_ff;
   logic [PIXEL_W-1:0]    pix_acc_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_payload_ff;

   // pixel store
   logic [PIXEL_W-1:0]    store_mem [MAX_WIDTH * MAX_HEIGHT];
   logic [PIXEL_W-1:0]    rd_ff;

   // combinational helpers
   logic                  csr_wr;
   logic [2:0]            csr_idx;
   logic                  req_accept;
   logic [SIZE_W-1:0]     w_sat, h_sat;
   logic signed [3:0]     r_s;
   logic [SIZE_W-1:0]     nx, ny;
   logic signed [SIZE_W:0] nx_s, ny_s;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WEIGHT_W-1:0]   wx, wy;
   logic [PIXEL_W-1:0]    pix_masked;
   logic [1:0]            chan_sel;
   logic [7:0]            chan;
   logic [WT_W-1:0]       mul_a;
   logic [WEIGHT_W-1:0]   mul_b;
   logic [SUM_W-1:0]      div_sub;
   logic                  div_ge;
   logic [7:0]            quot_next;

   function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
      return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
   endfunction

   function automatic logic [1:0] abs_off(input logic signed [3:0] d);
      logic signed [3:0] m;
      m = d[3] ? -d : d;
      return m[1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_coord(input logic signed [SIZE_W:0] v,
                                                     input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] res;
      if (v[SIZE_W]) begin
         res = '0;
      end else if (v[SIZE_W-1:0] >= size) begin
         res = size - SIZE_W'(1);
      end else begin
         res = v[SIZE_W-1:0];
      end
      return res;
   endfunction

   // csr access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_W'(MAX_WIDTH);
         height_ff    <= SIZE_W'(MAX_HEIGHT);
         radius_ff    <= RADIUS_W'(1);
         weight_ff[0] <= 16'd32768;
         weight_ff[1] <= 16'd19874;
         weight_ff[2] <= 16'd4435;
         weight_ff[3] <= 16'd364;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_IMAGE_WIDTH:  width_ff     <= csr_pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff    <= csr_pwdata[SIZE_W-1:0];
            REG_BLUR_RADIUS:  radius_ff    <= csr_pwdata[RADIUS_W-1:0];
            REG_WEIGHT_ZERO:  weight_ff[0] <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_ONE:   weight_ff[1] <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_TWO:   weight_ff[2] <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_THREE: weight_ff[3] <= csr_pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // csr read mux
   always_comb begin
      unique case (csr_idx)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_BLUR_RADIUS:  csr_prdata = CSR_DATA_W'(radius_ff);
         REG_WEIGHT_ZERO:  csr_prdata = CSR_DATA_W'(weight_ff[0]);
         REG_WEIGHT_ONE:   csr_prdata = CSR_DATA_W'(weight_ff[1]);
         REG_WEIGHT_TWO:   csr_prdata = CSR_DATA_W'(weight_ff[2]);
         REG_WEIGHT_THREE: csr_prdata = CSR_DATA_W'(weight_ff[3]);
         default:          csr_prdata = '0;
      endcase
   end

   // handshake
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // image size limited to the store
   assign w_sat = (width_ff  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : width_ff;
   assign h_sat = (height_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_ff;
   assign r_s   = $signed({2'b00, radius_ff});

   // window tap address with clamp to edge
   assign nx_s    = $signed({2'b00, col_ff}) + $signed({{(SIZE_W-3){dx_ff[3]}}, dx_ff});
   assign ny_s    = $signed({2'b00, row_ff}) + $signed({{(SIZE_W-3){dy_ff[3]}}, dy_ff});
   assign nx      = clamp_coord(nx_s, w_eff_ff);
   assign ny      = clamp_coord(ny_s, h_eff_ff);
   assign rd_addr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};

   // tap weights and channel of the fetched pixel, transparent counts as zero
   assign wx         = sat_weight(weight_ff[abs_off(dx_ff)]);
   assign wy         = sat_weight(weight_ff[abs_off(dy_ff)]);
   assign pix_masked = (rd_ff[31:24] == 8'h00) ? '0 : rd_ff;
   assign chan_sel   = step_ff[1:0] - 2'd2;
   assign chan       = pix_masked[8*chan_sel +: 8];

   // shared multiplier operands: tap weight first, then weight times channel
   always_comb begin
      if (step_ff == 3'd0) begin
         mul_a = WT_W'(wx);
         mul_b = wy;
      end else begin
         mul_a = wt_ff;
         mul_b = WEIGHT_W'(chan);
      end
   end

   // restoring division step
   assign div_sub   = SUM_W'(wsum_ff) << bit_ff;
   assign div_ge    = (rem_ff >= div_sub);
   assign quot_next = {quot_ff[6:0], div_ge};

   // pixel store write and registered read
   always_ff @(posedge clock) begin
      if (req_accept && req_payload.command == CMD_LOAD) begin
         store_mem[{req_payload.row, req_payload.col}] <= req_payload.pixel_in;
      end
      if (state_ff == ST_READ) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DELIVER) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_payload.command == CMD_BLUR) begin
                  col_ff   <= req_payload.col;
                  row_ff   <= req_payload.row;
                  state_ff <= ST_SETUP;
               end
            end
            // range check and window start
            ST_SETUP: begin
               w_eff_ff    <= w_sat;
               h_eff_ff    <= h_sat;
               dx_ff       <= -r_s;
               dy_ff       <= -r_s;
               step_ff     <= 3'd0;
               wsum_ff     <= '0;
               sum_ff[0]   <= '0;
               sum_ff[1]   <= '0;
               sum_ff[2]   <= '0;
               sum_ff[3]   <= '0;
               pix_acc_ff  <= '0;
               ch_ff       <= 2'd0;
               in_range_ff <= (SIZE_W'(col_ff) < w_sat) && (SIZE_W'(row_ff) < h_sat);
               if ((SIZE_W'(col_ff) < w_sat) && (SIZE_W'(row_ff) < h_sat)) begin
                  state_ff <= ST_READ;
               end else begin
                  state_ff <= ST_DELIVER;
               end
            end
            ST_READ: begin
               step_ff  <= 3'd0;
               state_ff <= ST_TAP;
            end
            // per tap: weight product, then four channel products
            ST_TAP: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff <= 3'd5) begin
                  mul_ff <= mul_a * mul_b;
               end
               if (step_ff == 3'd1) begin
                  wt_ff   <= mul_ff[WT_W-1:0];
                  wsum_ff <= wsum_ff + WSUM_W'(mul_ff[WT_W-1:0]);
               end
               if (step_ff >= 3'd3) begin
                  sum_ff[step_ff[1:0] - 2'd3] <= sum_ff[step_ff[1:0] - 2'd3] +
                                                 SUM_W'(mul_ff);
               end
               if (step_ff == 3'd6) begin
                  if (dx_ff == r_s) begin
                     dx_ff <= -r_s;
                     if (dy_ff == r_s) begin
                        state_ff <= ST_DIV_LOAD;
                     end else begin
                        dy_ff    <= dy_ff + 4'sd1;
                        state_ff <= ST_READ;
                     end
                  end else begin
                     dx_ff    <= dx_ff + 4'sd1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_DIV_LOAD: begin
               rem_ff   <= sum_ff[ch_ff];
               bit_ff   <= 3'd7;
               quot_ff  <= '0;
               state_ff <= ST_DIV_STEP;
            end
            // one quotient bit per cycle
            ST_DIV_STEP: begin
               if (div_ge) begin
                  rem_ff <= rem_ff - div_sub;
               end
               quot_ff <= quot_next;
               bit_ff  <= bit_ff - 3'd1;
               if (bit_ff == 3'd0) begin
                  if (wsum_ff != '0) begin
                     pix_acc_ff[8*ch_ff +: 8] <= quot_next;
                  end
                  ch_ff <= ch_ff + 2'd1;
                  if (ch_ff == 2'd3) begin
                     state_ff <= ST_DELIVER;
                  end else begin
                     state_ff <= ST_DIV_LOAD;
                  end
               end
            end
            // hold until the result register is free
            ST_DELIVER: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_payload_ff.in_range  <= in_range_ff;
                  rsp_payload_ff.pixel_out <= in_range_ff ? pix_acc_ff : '0;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.in_range |-> rsp_payload.pixel_out == '0)
      else $error("out-of-range item carries a nonzero pixel");

   a_tap_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAP |-> (dx_ff <= r_s) && (dx_ff >= -r_s) &&
                             (dy_ff <= r_s) && (dy_ff >= -r_s))
      else $error("window offset outside radius");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule
